>>> sv/hpbs_pkg.sv
`default_nettype none
package hpbs_pkg;

	// fixed field widths of the interface
	localparam int CRD_W = 19;
	localparam int CFG_W = 9;
	localparam int COL_W = 8;
	localparam int ROW_W = 8;

	localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

	typedef enum logic [0:0] {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

endpackage
`default_nettype wire

>>> sv/hpbs_ram.sv
`default_nettype none
module hpbs_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8385
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/hpbs_rem.sv
`default_nettype none
module hpbs_rem #(
	parameter int DW = 11,
	parameter int NW = 9,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          in_valid,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [NW-1:0] divisor,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic      [NW-1:0] rem,
	output logic      [SW-1:0] side_out
);

	// one restoring step per stage, msb of the dividend first
	logic          valid_s [DW+1];
	logic [DW-1:0] num_s   [DW+1];
	logic [NW-1:0] rem_s   [DW+1];
	logic [SW-1:0] side_s  [DW+1];
	logic [NW-1:0] rem_nxt [DW];

	for (genvar k = 0; k < DW; k++) begin : g_step
		logic [NW:0] trial;
		always_comb begin
			trial = {rem_s[k], num_s[k][DW-1-k]};
			if (trial >= {1'b0, divisor}) begin
				rem_nxt[k] = NW'(trial - {1'b0, divisor});
			end else begin
				rem_nxt[k] = NW'(trial);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DW; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (adv) begin
			valid_s[0] <= in_valid;
			for (int k = 0; k < DW; k++) begin
				valid_s[k+1] <= valid_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s[0]  <= dividend;
			rem_s[0]  <= '0;
			side_s[0] <= side_in;
			for (int k = 0; k < DW; k++) begin
				num_s[k+1]  <= num_s[k];
				rem_s[k+1]  <= rem_nxt[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = valid_s[DW];
	assign rem       = rem_s[DW];
	assign side_out  = side_s[DW];

endmodule
`default_nettype wire

>>> sv/half_plane_bilinear_sampler.sv
`default_nettype none
// Bilinear sampler over a stored half-plane complex image of N/2+1 columns by N rows.
// A write transaction (operation 0) stores one entry; a sample transaction
// (operation 1) returns one interpolated complex value, x clamped to [0, N/2],
// y wrapped modulo N, rounded to nearest with ties toward plus infinity.
// Throughput is one transaction per clock while the output is not stalled, writes and
// samples mixed in any order. A sample passes through the bit-per-stage remainder
// pipeline that wraps the row coordinate, then stages 1 to 4 and the result register.
// The image sits in four banks split by row and column parity, so all four neighbors
// are read in the same cycle. Row 0 is also kept as a shadow copy in the odd-row
// banks, which covers the wrap from row N-1 to row 0 for odd N. The whole pipeline
// stalls while a result waits on out_ready.
// image_size may only change while no transaction is in flight.
module half_plane_bilinear_sampler #(
	parameter int MAX_SIZE   = 256,
	parameter int VALUE_BITS = 24,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [hpbs_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           operation,
	input  wire logic [hpbs_pkg::COL_W-1:0]     write_column,
	input  wire logic [hpbs_pkg::ROW_W-1:0]     write_row,
	input  wire logic signed [VALUE_BITS-1:0]   write_real,
	input  wire logic signed [VALUE_BITS-1:0]   write_imag,
	input  wire logic signed [hpbs_pkg::CRD_W-1:0] pos_x,
	input  wire logic signed [hpbs_pkg::CRD_W-1:0] pos_y,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [VALUE_BITS-1:0]        result_real,
	output logic signed [VALUE_BITS-1:0]        result_imag
);

	localparam int FB       = FRAC_BITS;
	localparam int VB       = VALUE_BITS;
	localparam int CRD      = hpbs_pkg::CRD_W;
	localparam int IB       = CRD - FB;
	localparam int NB       = $clog2(MAX_SIZE + 1);
	localparam int CW       = (NB > hpbs_pkg::CFG_W) ? NB : hpbs_pkg::CFG_W;
	localparam int XW       = ((IB - 1) > NB) ? (IB - 1) : NB;
	localparam int COLS     = MAX_SIZE / 2 + 1;
	localparam int CB       = $clog2(COLS + 1);
	localparam int COPY_ROW = MAX_SIZE + 1;
	localparam int RB       = $clog2(MAX_SIZE + 2);
	localparam int YW       = ((RB > NB) ? RB : NB) + 1;
	localparam int BC       = MAX_SIZE / 4 + 1;
	localparam int BR       = MAX_SIZE / 2 + 1;
	localparam int DEPTH    = BR * BC;
	localparam int AW       = $clog2(DEPTH);
	localparam int DW       = 2 * VB;
	localparam int R1W      = VB + FB + 2;
	localparam int ACCW     = VB + 2 * FB + 3;

	typedef struct packed {
		logic          sample;
		logic          wok;
		logic          xlast;
		logic          yneg;
		logic [CB-1:0] x0;
		logic [FB-1:0] tx;
		logic [FB-1:0] ty;
		logic [CB-1:0] wcol;
		logic [RB-1:0] wrow;
		logic [VB-1:0] wre;
		logic [VB-1:0] wim;
	} side_t;

	localparam int SW = $bits(side_t);

	// entry address inside one parity bank
	function automatic logic [AW-1:0] bank_addr(input logic [RB-1:0] r,
		input logic [CB-1:0] c);
		return AW'(AW'(r >> 1) * AW'(BC) + AW'(c >> 1));
	endfunction

	// configuration
	logic [hpbs_pkg::CFG_W-1:0] image_size_q;
	logic [NB-1:0]              n_eff;
	logic [NB-1:0]              half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= hpbs_pkg::CFG_RESET;
		end else if (cfg_write) begin
			image_size_q <= cfg_data;
		end
	end

	// out-of-range sizes act as the nearest legal size
	always_comb begin
		if (CW'(image_size_q) < CW'(2)) begin
			n_eff = NB'(2);
		end else if (CW'(image_size_q) > CW'(MAX_SIZE)) begin
			n_eff = NB'(MAX_SIZE);
		end else begin
			n_eff = NB'(image_size_q);
		end
	end

	assign half = n_eff >> 1;

	// whole pipeline moves unless a result in the output register waits on out_ready
	logic adv;
	logic out_valid_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// input: clamp x, split y into sign and magnitude of its integer part
	side_t           side_in;
	logic [IB-1:0]   iy;
	logic [IB-1:0]   ymag;
	logic [IB-2:0]   ix;

	always_comb begin
		ix = pos_x[CRD-2:FB];
		iy = pos_y[CRD-1:FB];
		side_in.sample = (operation == hpbs_pkg::OP_SAMPLE);
		side_in.yneg   = iy[IB-1];
		side_in.ty     = pos_y[FB-1:0];
		if (pos_x[CRD-1]) begin
			side_in.x0 = '0;
			side_in.tx = '0;
		end else if (XW'(ix) >= XW'(half)) begin
			side_in.x0 = CB'(half);
			side_in.tx = '0;
		end else begin
			side_in.x0 = CB'(ix);
			side_in.tx = pos_x[FB-1:0];
		end
		side_in.xlast = (XW'(side_in.x0) == XW'(half));
		side_in.wok   = (CW'(write_column) <= CW'(half)) && (CW'(write_row) < CW'(n_eff));
		side_in.wcol  = CB'(write_column);
		side_in.wrow  = RB'(write_row);
		side_in.wre   = write_real;
		side_in.wim   = write_imag;
		ymag = iy[IB-1] ? IB'(~iy + IB'(1)) : iy;
	end

	// row wrap: |iy| mod N, one quotient bit per stage
	logic          rem_valid;
	logic [NB-1:0] rem;
	logic [SW-1:0] rem_side;

	hpbs_rem #(
		.DW(IB),
		.NW(NB),
		.SW(SW)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid && adv),
		.dividend (ymag),
		.divisor  (n_eff),
		.side_in  (side_in),
		.out_valid(rem_valid),
		.rem      (rem),
		.side_out (rem_side)
	);

	// stage 1: final row pair, then bank access
	side_t         side_r;
	logic [NB-1:0] y0w;
	logic [RB-1:0] y0;
	logic [RB-1:0] y1;

	assign side_r = side_t'(rem_side);

	always_comb begin
		// negative rows fold back from N
		if (side_r.yneg && (rem != '0)) begin
			y0w = n_eff - rem;
		end else begin
			y0w = rem;
		end
		y0 = RB'(y0w);
		if (YW'(y0) + YW'(1) < YW'(n_eff)) begin
			y1 = RB'(y0 + RB'(1));
		end else if (n_eff[0]) begin
			// odd N: row 0 via its shadow in the odd-row banks
			y1 = RB'(COPY_ROW);
		end else begin
			y1 = '0;
		end
	end

	logic          valid_s1;
	side_t         side_s1;
	logic [RB-1:0] y0_s1;
	logic [RB-1:0] y1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= rem_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_r;
			y0_s1   <= y0;
			y1_s1   <= y1;
		end
	end

	// even and odd members of the column and row pairs
	logic [CB-1:0] x1_s1;
	logic [CB-1:0] col_e;
	logic [CB-1:0] col_o;
	logic [RB-1:0] row_e;
	logic [RB-1:0] row_o;
	logic          wr_go;

	always_comb begin
		x1_s1 = CB'(side_s1.x0 + CB'(1));
		col_e = side_s1.x0[0] ? x1_s1 : side_s1.x0;
		col_o = side_s1.x0[0] ? side_s1.x0 : x1_s1;
		row_e = y0_s1[0] ? y1_s1 : y0_s1;
		row_o = y0_s1[0] ? y0_s1 : y1_s1;
		wr_go = adv && valid_s1 && !side_s1.sample && side_s1.wok;
	end

	logic [DW-1:0] rd [4];

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam bit RP = ((b / 2) == 1);
		localparam bit CP = ((b % 2) == 1);

		logic          we;
		logic [RB-1:0] wr_row;
		logic [AW-1:0] waddr;
		logic [AW-1:0] raddr;

		always_comb begin
			// odd-row banks also take the shadow of row 0
			wr_row = (side_s1.wrow[0] == RP) ? side_s1.wrow : RB'(COPY_ROW);
			waddr  = bank_addr(wr_row, side_s1.wcol);
			raddr  = bank_addr(RP ? row_o : row_e, CP ? col_o : col_e);
			we     = wr_go && (side_s1.wcol[0] == CP) &&
				((side_s1.wrow[0] == RP) || (RP && (side_s1.wrow == '0)));
		end

		hpbs_ram #(
			.WIDTH(DW),
			.DEPTH(DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(waddr),
			.wdata({side_s1.wre, side_s1.wim}),
			.re   (adv),
			.raddr(raddr),
			.rdata(rd[b])
		);
	end

	// stage 2: bank data arrives, blend along x
	logic          valid_s2;
	logic [FB-1:0] tx_s2;
	logic [FB-1:0] ty_s2;
	logic          xodd_s2;
	logic          yodd_s2;
	logic          xlast_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && side_s1.sample;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tx_s2    <= side_s1.tx;
			ty_s2    <= side_s1.ty;
			xodd_s2  <= side_s1.x0[0];
			yodd_s2  <= y0_s1[0];
			xlast_s2 <= side_s1.xlast;
		end
	end

	logic [DW-1:0]         v00;
	logic [DW-1:0]         v10;
	logic [DW-1:0]         v01;
	logic [DW-1:0]         v11;
	logic [FB:0]           wx0;
	logic [FB:0]           wx1;
	logic signed [R1W-1:0] r0_re;
	logic signed [R1W-1:0] r1_re;
	logic signed [R1W-1:0] r0_im;
	logic signed [R1W-1:0] r1_im;

	always_comb begin
		v00 = rd[{yodd_s2, xodd_s2}];
		v01 = rd[{!yodd_s2, xodd_s2}];
		// at the last column the right neighbor has zero weight; use the left one
		v10 = xlast_s2 ? v00 : rd[{yodd_s2, !xodd_s2}];
		v11 = xlast_s2 ? v01 : rd[{!yodd_s2, !xodd_s2}];
		wx1 = {1'b0, tx_s2};
		wx0 = {1'b1, FB'(0)} - wx1;
		r0_re = R1W'($signed({1'b0, wx0})) * R1W'($signed(v00[DW-1:VB])) +
			R1W'($signed({1'b0, wx1})) * R1W'($signed(v10[DW-1:VB]));
		r1_re = R1W'($signed({1'b0, wx0})) * R1W'($signed(v01[DW-1:VB])) +
			R1W'($signed({1'b0, wx1})) * R1W'($signed(v11[DW-1:VB]));
		r0_im = R1W'($signed({1'b0, wx0})) * R1W'($signed(v00[VB-1:0])) +
			R1W'($signed({1'b0, wx1})) * R1W'($signed(v10[VB-1:0]));
		r1_im = R1W'($signed({1'b0, wx0})) * R1W'($signed(v01[VB-1:0])) +
			R1W'($signed({1'b0, wx1})) * R1W'($signed(v11[VB-1:0]));
	end

	// stage 3: blend along y
	logic                  valid_s3;
	logic [FB-1:0]         ty_s3;
	logic signed [R1W-1:0] r0_re_s3;
	logic signed [R1W-1:0] r1_re_s3;
	logic signed [R1W-1:0] r0_im_s3;
	logic signed [R1W-1:0] r1_im_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ty_s3    <= ty_s2;
			r0_re_s3 <= r0_re;
			r1_re_s3 <= r1_re;
			r0_im_s3 <= r0_im;
			r1_im_s3 <= r1_im;
		end
	end

	logic [FB:0]            wy0;
	logic [FB:0]            wy1;
	logic signed [ACCW-1:0] acc_re;
	logic signed [ACCW-1:0] acc_im;

	always_comb begin
		wy1 = {1'b0, ty_s3};
		wy0 = {1'b1, FB'(0)} - wy1;
		acc_re = ACCW'($signed({1'b0, wy0})) * ACCW'(r0_re_s3) +
			ACCW'($signed({1'b0, wy1})) * ACCW'(r1_re_s3);
		acc_im = ACCW'($signed({1'b0, wy0})) * ACCW'(r0_im_s3) +
			ACCW'($signed({1'b0, wy1})) * ACCW'(r1_im_s3);
	end

	// stage 4: round into the output register
	logic                   valid_s4;
	logic signed [ACCW-1:0] acc_re_s4;
	logic signed [ACCW-1:0] acc_im_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_re_s4 <= acc_re;
			acc_im_s4 <= acc_im;
		end
	end

	// floor of (acc + half lsb): nearest, ties toward plus infinity
	logic signed [ACCW-1:0] rnd_re;
	logic signed [ACCW-1:0] rnd_im;

	always_comb begin
		rnd_re = (acc_re_s4 + (ACCW'(1) <<< (2 * FB - 1))) >>> (2 * FB);
		rnd_im = (acc_im_s4 + (ACCW'(1) <<< (2 * FB - 1))) >>> (2 * FB);
	end

	logic signed [VB-1:0] result_real_q;
	logic signed [VB-1:0] result_imag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s4) begin
			result_real_q <= VB'(rnd_re);
			result_imag_q <= VB'(rnd_im);
		end
	end

	assign out_valid   = out_valid_q;
	assign result_real = result_real_q;
	assign result_imag = result_imag_q;

endmodule
`default_nettype wire
